@@ rtl/core/cds_pkg.sv @@
package cds_pkg;

  // Fixed widths of the external fields.
  localparam int RAND_W = 31;
  localparam int POS_W  = 6;
  localparam int SUIT_W = 2;
  localparam int RANK_W = 4;

  // A card is held as suit * values_per_suit + (value - 1).
  localparam int CARD_W = 6;

  // The divisor (cards left to place) runs up to 64.
  localparam int DIVR_W = 7;

  // One remainder bit is produced per cycle.
  localparam int DIV_STEPS = RAND_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD_I,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J,
    ST_EMIT,
    ST_RD_LAST
  } cds_state_t;

  // Progress through the extra word that closes a pass: read issued or not.
  typedef enum logic {
    EMIT_SWAP,
    EMIT_FINAL
  } cds_emit_t;

endpackage

@@ rtl/core/card_deck_shuffler.sv @@
// Step-wise Fisher-Yates shuffler for a deck of SUIT_COUNT * VALUES_PER_SUIT cards, which
// reset leaves in suit-major order with values 1 to VALUES_PER_SUIT. Each input word carries
// one random value; the block reduces it modulo the number of cards still unplaced, swaps the
// card at the current position with the card so chosen, and returns one output word giving the
// position, suit and rank of the card now fixed there. The step that places the second-last
// card also returns a second word for the final card, with last set, and the next input word
// starts a fresh pass over the deck as it now stands. With the output register free, an item
// goes from acceptance to its first output word through the bit-serial remainder of the 31-bit
// random value, two reads and two writes on the deck memory, and the load of the output
// register; no new input word is taken before that word is loaded.
// The final word of a pass needs a further deck read. A receiver that holds off keeps
// the block waiting until the output register is free. The deck needs no clearing pass after
// reset, since per-entry valid flags make untouched entries read as their ordered value.
// Only one item is worked on at a time, but a finished word may wait in the output register
// while the next input word is already being taken and reduced.
module card_deck_shuffler
  import cds_pkg::*;
#(
  parameter int VALUES_PER_SUIT = 13,
  parameter int SUIT_COUNT      = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [RAND_W-1:0] random_value,
  output logic              card_valid,
  input  logic              card_ready,
  output logic [POS_W-1:0]  position,
  output logic [SUIT_W-1:0] suit,
  output logic [RANK_W-1:0] rank,
  output logic              last
);

  localparam int DECK_SIZE = SUIT_COUNT * VALUES_PER_SUIT;
  localparam int ADDR_W    = $clog2(DECK_SIZE);

  localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(DECK_SIZE - 1);
  localparam logic [POS_W-1:0]  POS_FINISH = POS_W'(DECK_SIZE - 2);
  localparam logic [DIVR_W-1:0] DECK_CNT   = DIVR_W'(DECK_SIZE);

  // Control state.
  cds_state_t state, state_next;
  logic [POS_W-1:0] shuffle_position;

  // Working registers for the item in flight.
  logic [POS_W-1:0]  pos_i;
  logic [POS_W-1:0]  pos_j;
  logic [DIVR_W-1:0] divisor;
  logic [RAND_W-1:0] dividend;
  logic [POS_W-1:0]  remainder;
  logic [STEP_W-1:0] step;
  logic [CARD_W-1:0] card_i;
  logic [CARD_W-1:0] card_j;

  // Deck memory with a single read and a single write port; read data is registered.
  logic [CARD_W-1:0] deck_mem [DECK_SIZE];
  logic [DECK_SIZE-1:0] loaded;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] rd_addr_q;
  logic [CARD_W-1:0] rd_data;
  logic              rd_loaded;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CARD_W-1:0] wr_data;
  logic [CARD_W-1:0] rd_card;

  // Handshake and output selection.
  logic              item_take;
  logic              out_free;
  logic              out_load;
  cds_emit_t         emit_kind;
  logic [POS_W-1:0]  emit_pos;
  logic [CARD_W-1:0] emit_card;
  logic [SUIT_W-1:0] emit_suit;
  logic [RANK_W-1:0] emit_rank;
  logic [POS_W-1:0]  start_pos;

  // Remainder step.
  logic [DIVR_W-1:0] trial;
  logic              trial_fits;
  logic [POS_W-1:0]  remainder_next;

  assign item_take = item_valid && item_ready;
  assign out_free  = !card_valid || card_ready;

  // A position register never leaves range, but an out-of-range value restarts the pass.
  assign start_pos = (shuffle_position >= POS_LAST) ? '0 : shuffle_position;

  // Restoring remainder: bring down one dividend bit and subtract when it fits.
  assign trial          = {remainder, dividend[RAND_W-1]};
  assign trial_fits     = trial >= divisor;
  assign remainder_next = trial_fits ? POS_W'(trial - divisor) : POS_W'(trial);

  // Entries not yet written still hold the ordered deck, where entry k is card k.
  assign rd_card = rd_loaded ? rd_data : CARD_W'(rd_addr_q);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_take) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_RD_I;
        end
      end
      ST_RD_I: state_next = ST_RD_J;
      ST_RD_J: state_next = ST_WR_I;
      ST_WR_I: state_next = ST_WR_J;
      ST_WR_J: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = (pos_i == POS_FINISH) ? ST_RD_LAST : ST_IDLE;
        end
      end
      ST_RD_LAST: begin
        if (out_free && emit_kind == EMIT_FINAL) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs for the memory and the output register.
  always_comb begin
    item_ready = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = ADDR_W'(pos_i);
    wr_en      = 1'b0;
    wr_addr    = ADDR_W'(pos_i);
    wr_data    = rd_card;
    out_load   = 1'b0;
    emit_pos   = pos_i;
    emit_card  = card_j;
    case (state)
      ST_IDLE: item_ready = 1'b1;
      ST_RD_I: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(pos_i);
      end
      ST_RD_J: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(pos_j);
      end
      ST_WR_I: begin
        // The card drawn from position j becomes final at position i.
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(pos_i);
        wr_data = rd_card;
      end
      ST_WR_J: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(pos_j);
        wr_data = card_i;
      end
      ST_EMIT: out_load = out_free;
      ST_RD_LAST: begin
        // The first cycle issues the read; the word is loaded once the data is back.
        rd_en     = (emit_kind == EMIT_SWAP);
        rd_addr   = ADDR_W'(POS_LAST);
        out_load  = out_free && emit_kind == EMIT_FINAL;
        emit_pos  = POS_LAST;
        emit_card = rd_card;
      end
      default: ;
    endcase
  end

  // Split a card code into suit and value by comparing against each suit boundary.
  always_comb begin
    emit_suit = '0;
    for (int s = 1; s < SUIT_COUNT; s++) begin
      if (emit_card >= CARD_W'(s * VALUES_PER_SUIT)) begin
        emit_suit = SUIT_W'(s);
      end
    end
    emit_rank = RANK_W'(emit_card - CARD_W'(emit_suit) * CARD_W'(VALUES_PER_SUIT)
                        + CARD_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      shuffle_position <= '0;
      card_valid       <= 1'b0;
      emit_kind        <= EMIT_SWAP;
    end else begin
      state <= state_next;
      if (out_load) begin
        card_valid <= 1'b1;
      end else if (card_ready) begin
        card_valid <= 1'b0;
      end
      if (state == ST_EMIT && out_free) begin
        shuffle_position <= (pos_i == POS_FINISH) ? '0 : POS_W'(pos_i + POS_W'(1));
      end
      // Marks whether the read of the final card has been issued.
      if (state == ST_RD_LAST) begin
        if (emit_kind == EMIT_SWAP) begin
          emit_kind <= EMIT_FINAL;
        end else if (out_free) begin
          emit_kind <= EMIT_SWAP;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (item_take) begin
      pos_i     <= start_pos;
      divisor   <= DECK_CNT - DIVR_W'(start_pos);
      dividend  <= random_value;
      remainder <= '0;
      step      <= '0;
    end else if (state == ST_DIV) begin
      remainder <= remainder_next;
      dividend  <= {dividend[RAND_W-2:0], 1'b0};
      step      <= STEP_W'(step + STEP_W'(1));
    end
    if (state == ST_RD_I) begin
      pos_j <= POS_W'(pos_i + remainder);
    end
    if (state == ST_RD_J) begin
      card_i <= rd_card;
    end
    if (state == ST_WR_I) begin
      card_j <= rd_card;
    end
    if (out_load) begin
      position <= emit_pos;
      suit     <= emit_suit;
      rank     <= emit_rank;
      last     <= (state == ST_RD_LAST);
    end
  end

  // Deck memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      deck_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data   <= deck_mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Written flags; reset returns every entry to its ordered value at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded    <= '0;
      rd_loaded <= 1'b0;
    end else begin
      if (wr_en) begin
        loaded[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_loaded <= loaded[rd_addr];
      end
    end
  end

endmodule
